[design/bmp_dec_pkg.sv]
// ----------------------------------------------------------------------------
// bmp_dec_pkg
// shared constants and types of the bmp stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

package bmp_dec_pkg;

   localparam int unsigned MaxWidth    = 4096;
   localparam int unsigned MaxHeight   = 4096;
   localparam int unsigned PalDepth    = 256;
   localparam int unsigned DimW        = 13;
   localparam int unsigned HeaderLast  = 53;
   localparam int unsigned HeaderBytes = 54;

   localparam logic [15:0] BmMagic   = 16'd19778;
   localparam logic [31:0] InfoSize  = 32'd40;

   localparam logic [5:0] HcMagic    = 6'd1;
   localparam logic [5:0] HcOffset   = 6'd13;
   localparam logic [5:0] HcInfo     = 6'd17;
   localparam logic [5:0] HcWidth    = 6'd21;
   localparam logic [5:0] HcHeight   = 6'd25;
   localparam logic [5:0] HcDepth    = 6'd29;
   localparam logic [5:0] HcCompress = 6'd33;
   localparam logic [5:0] HcEnd      = 6'd53;

   typedef enum logic [2:0] {
      KIND_PIXEL     = 3'd0,
      KIND_BAD_MAGIC = 3'd1,
      KIND_BAD_SIZE  = 3'd2,
      KIND_COMPRESS  = 3'd3,
      KIND_BAD_DEPTH = 3'd4,
      KIND_TOO_LARGE = 3'd5
   } kind_type;

   localparam int unsigned ReqDataW = 8;
   localparam int unsigned RspDataW = 56;

endpackage

`default_nettype wire

[design/bmp_stream_decoder.sv]
// ----------------------------------------------------------------------------
// bmp_stream_decoder
// uncompressed bmp parser taking one file byte per item
// ----------------------------------------------------------------------------
// req channel: one file byte in tdata, tuser high on byte 0 of a new file.
// rsp channel: one result per item, either a pixel (x, y, rgb) or a header
// fault status; tlast marks the final result caused by a byte, tuser marks
// the last pixel of the image.
// header, palette, padding and 8/24-bit data bytes each pass without holding
// the input, so bytes stream at one per cycle while rsp does not stall. a 4-bit
// or 1-bit byte holds the input until all its pixels are out, one pixel per
// cycle on the rsp side while rsp does not stall; the pixel expansion sequencer
// steps through them. a byte's first result shows on rsp in the cycle after
// its accept; the palette memory read is registered into the result stage.
// when rsp stalls, the result register holds and req_tready drops.
// reset clears the parser to the header phase and marks all 256 palette
// entries as unloaded (read as black) at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_stream_decoder (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire  [bmp_dec_pkg::ReqDataW-1:0]       req_tdata,  // data_byte
   input  wire                                    req_tuser,  // start_file
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   // kind, pixel_x, pixel_y, red, green, blue, zero fill
   output logic [bmp_dec_pkg::RspDataW-1:0]       rsp_tdata,
   output logic                                   rsp_tlast,  // last_of_byte
   output logic                                   rsp_tuser   // image_done
);
   import bmp_dec_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_PREAMBLE,
      PH_DATA,
      PH_PAD,
      PH_IDLE
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [5:0]       hc_ff, hc_in;
   logic [31:0]      fa_ff, fa_in;
   logic [31:0]      offs_ff, offs_in;
   logic [DimW-1:0]  width_ff, width_in;
   logic [DimW-1:0]  height_ff, height_in;
   logic [4:0]       bpp_ff, bpp_in;
   logic [8:0]       pcount_ff, pcount_in;
   logic [DimW-1:0]  row_ff, row_in;
   logic [DimW-1:0]  col_ff, col_in;
   logic [1:0]       rbp_ff, rbp_in;
   logic [1:0]       lane_ff, lane_in;
   logic [15:0]      part_ff, part_in;
   logic [2:0]       fault_ff, fault_in;
   logic [31:0]      rel_ff, rel_in;
   logic             busy_ff, busy_in;
   logic [7:0]       byte_ff, byte_in;
   logic [2:0]       sub_ff, sub_in;

   logic [23:0]      pal_mem [PalDepth];
   logic [PalDepth-1:0] pal_valid_ff;

   logic             rsp_valid_ff;
   kind_type         kind_ff;
   logic [11:0]      x_ff, y_ff;
   logic [23:0]      rgb_ff;
   logic             use_pal_ff, last_ff, done_ff;
   logic [23:0]      pal_q_ff;
   logic             pal_v_ff;

   logic             out_free, req_fire;
   logic             emit, e_use_pal, e_last, e_done;
   kind_type         e_kind;
   logic [11:0]      e_x, e_y;
   logic [23:0]      e_rgb;
   logic [7:0]       e_idx;
   logic             pal_we;
   logic [7:0]       pal_wa;
   logic [23:0]      pal_wd;

   logic             pix_go, eob, pad_step, end_row;
   logic [7:0]       pix_byte, b;
   logic [2:0]       pix_sub;
   logic [31:0]      diff;
   logic [31:0]      rel_n;
   logic [32:0]      fpos_n;
   logic [15:0]      depth;
   logic [DimW-1:0]  col_n;
   logic             px_last;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !busy_ff && out_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      phase_in  = phase_ff;
      hc_in     = hc_ff;
      fa_in     = fa_ff;
      offs_in   = offs_ff;
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      pcount_in = pcount_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      rbp_in    = rbp_ff;
      lane_in   = lane_ff;
      part_in   = part_ff;
      fault_in  = fault_ff;
      rel_in    = rel_ff;
      busy_in   = busy_ff;
      byte_in   = byte_ff;
      sub_in    = sub_ff;
      emit      = 1'b0;
      e_kind    = KIND_PIXEL;
      e_x       = col_ff[11:0];
      e_y       = 12'(height_ff - DimW'(1) - row_ff);
      e_rgb     = '0;
      e_idx     = '0;
      e_use_pal = 1'b0;
      e_last    = 1'b1;
      e_done    = (row_ff + DimW'(1) == height_ff) && (col_ff + DimW'(1) == width_ff);
      pal_we    = 1'b0;
      pal_wa    = '0;
      pal_wd    = '0;
      pix_go    = 1'b0;
      pix_byte  = req_tdata;
      pix_sub   = '0;
      eob       = 1'b0;
      pad_step  = 1'b0;
      end_row   = 1'b0;
      b         = req_tdata;
      diff      = offs_ff - 32'(HeaderBytes);
      rel_n     = rel_ff + 32'd1;
      fpos_n    = {1'b0, rel_n} + 33'(HeaderBytes);
      depth     = '0;
      col_n     = col_ff + DimW'(1);
      px_last   = 1'b0;

      if (busy_ff) begin
         if (out_free) begin
            pix_go   = 1'b1;
            pix_byte = byte_ff;
            pix_sub  = sub_ff;
         end
      end else if (req_fire) begin
         if (req_tuser) begin
            phase_in = PH_HEADER;
            hc_in    = '0;
            fault_in = '0;
         end
         unique case (phase_in)
            PH_HEADER: begin
               fa_in = {b, fa_ff[31:8]};
               hc_in = hc_in + 6'd1;
               if (hc_in == HcMagic + 6'd1 && fa_in[31:16] != BmMagic) begin
                  if (fault_in == '0 || KIND_BAD_MAGIC < fault_in) fault_in = KIND_BAD_MAGIC;
               end
               if (hc_in == HcOffset + 6'd1) offs_in = fa_in;
               if (hc_in == HcInfo + 6'd1 && fa_in != InfoSize) begin
                  if (fault_in == '0 || KIND_BAD_SIZE < fault_in) fault_in = KIND_BAD_SIZE;
               end
               if (hc_in == HcWidth + 6'd1) begin
                  width_in = fa_in[DimW-1:0];
                  if (fa_in > 32'(MaxWidth)) begin
                     if (fault_in == '0 || KIND_TOO_LARGE < fault_in)
                        fault_in = KIND_TOO_LARGE;
                  end
               end
               if (hc_in == HcHeight + 6'd1) begin
                  height_in = fa_in[DimW-1:0];
                  if (fa_in > 32'(MaxHeight)) begin
                     if (fault_in == '0 || KIND_TOO_LARGE < fault_in)
                        fault_in = KIND_TOO_LARGE;
                  end
               end
               if (hc_in == HcDepth + 6'd1) begin
                  depth  = fa_in[31:16];
                  bpp_in = depth[4:0];
                  if (depth != 16'd1 && depth != 16'd4 && depth != 16'd8 && depth != 16'd24) begin
                     if (fault_in == '0 || KIND_BAD_DEPTH < fault_in)
                        fault_in = KIND_BAD_DEPTH;
                  end
               end
               if (hc_in == HcCompress + 6'd1 && fa_in != '0) begin
                  if (fault_in == '0 || KIND_COMPRESS < fault_in) fault_in = KIND_COMPRESS;
               end
               if (hc_in == HcEnd + 6'd1) begin
                  if (fault_in != '0) begin
                     emit     = 1'b1;
                     e_kind   = kind_type'(fault_in);
                     e_x      = '0;
                     e_y      = '0;
                     e_done   = 1'b0;
                     phase_in = PH_IDLE;
                  end else begin
                     if (offs_ff < 32'(HeaderBytes)) pcount_in = '0;
                     else if (diff[31:10] != '0) pcount_in = 9'(PalDepth);
                     else pcount_in = {1'b0, diff[9:2]};
                     rel_in  = '0;
                     row_in  = '0;
                     col_in  = '0;
                     rbp_in  = '0;
                     lane_in = '0;
                     if (width_ff == '0 || height_ff == '0) phase_in = PH_IDLE;
                     else if (pcount_in != '0 || offs_ff > 32'(HeaderBytes))
                        phase_in = PH_PREAMBLE;
                     else phase_in = PH_DATA;
                  end
               end
            end
            PH_PREAMBLE: begin
               if (rel_ff[31:10] == '0 && {1'b0, rel_ff[9:2]} < pcount_ff) begin
                  unique case (rel_ff[1:0])
                     2'd0: part_in = {8'd0, b};
                     2'd1: part_in = {b, part_ff[7:0]};
                     2'd2: begin
                        pal_we = 1'b1;
                        pal_wa = rel_ff[9:2];
                        pal_wd = {b, part_ff};
                     end
                     default: ;
                  endcase
               end
               rel_in = rel_n;
               if (rel_n >= {21'd0, pcount_ff, 2'b00} && fpos_n >= {1'b0, offs_ff})
                  phase_in = PH_DATA;
            end
            PH_DATA: begin
               if (bpp_ff == 5'd24) begin
                  unique case (lane_ff)
                     2'd0: begin
                        part_in = {8'd0, b};
                        lane_in = 2'd1;
                     end
                     2'd1: begin
                        part_in = {b, part_ff[7:0]};
                        lane_in = 2'd2;
                     end
                     default: begin
                        emit    = 1'b1;
                        e_rgb   = {b, part_ff};
                        col_in  = col_n;
                        lane_in = 2'd0;
                     end
                  endcase
                  eob = 1'b1;
               end else if (bpp_ff == 5'd8) begin
                  emit      = 1'b1;
                  e_use_pal = 1'b1;
                  e_idx     = b;
                  col_in    = col_n;
                  eob       = 1'b1;
               end else begin
                  pix_go = 1'b1;
               end
            end
            PH_PAD: pad_step = 1'b1;
            default: ;
         endcase
      end

      if (pix_go) begin
         emit      = 1'b1;
         e_use_pal = 1'b1;
         col_in    = col_n;
         if (bpp_ff == 5'd4) begin
            e_idx   = pix_sub[0] ? {4'd0, pix_byte[3:0]} : {4'd0, pix_byte[7:4]};
            px_last = pix_sub == 3'd1;
         end else begin
            e_idx   = {7'd0, pix_byte[3'd7 - pix_sub]};
            px_last = pix_sub == 3'd7;
         end
         px_last = px_last || (col_n == width_ff);
         e_last  = px_last;
         if (px_last) begin
            busy_in = 1'b0;
            eob     = 1'b1;
         end else begin
            busy_in = 1'b1;
            byte_in = pix_byte;
            sub_in  = pix_sub + 3'd1;
         end
      end

      if (eob) begin
         rbp_in = rbp_ff + 2'd1;
         if (col_in >= width_ff) begin
            if (rbp_in == 2'd0) end_row = 1'b1;
            else phase_in = PH_PAD;
         end
      end
      if (pad_step) begin
         rbp_in = rbp_ff + 2'd1;
         if (rbp_in == 2'd0) end_row = 1'b1;
      end
      if (end_row) begin
         row_in   = row_ff + DimW'(1);
         col_in   = '0;
         rbp_in   = '0;
         lane_in  = '0;
         phase_in = (row_in >= height_ff) ? PH_IDLE : PH_DATA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hc_ff        <= '0;
         fa_ff        <= '0;
         offs_ff      <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         bpp_ff       <= '0;
         pcount_ff    <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rbp_ff       <= '0;
         lane_ff      <= '0;
         part_ff      <= '0;
         fault_ff     <= '0;
         rel_ff       <= '0;
         busy_ff      <= 1'b0;
         byte_ff      <= '0;
         sub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pal_valid_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         hc_ff     <= hc_in;
         fa_ff     <= fa_in;
         offs_ff   <= offs_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         bpp_ff    <= bpp_in;
         pcount_ff <= pcount_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         rbp_ff    <= rbp_in;
         lane_ff   <= lane_in;
         part_ff   <= part_in;
         fault_ff  <= fault_in;
         rel_ff    <= rel_in;
         busy_ff   <= busy_in;
         byte_ff   <= byte_in;
         sub_ff    <= sub_in;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (pal_we) pal_valid_ff[pal_wa] <= 1'b1;
      end
   end

   // palette memory and result register
   always_ff @(posedge clock) begin
      if (pal_we) pal_mem[pal_wa] <= pal_wd;
      if (emit) begin
         kind_ff    <= e_kind;
         x_ff       <= e_x;
         y_ff       <= e_y;
         rgb_ff     <= e_rgb;
         use_pal_ff <= e_use_pal;
         last_ff    <= e_last;
         done_ff    <= e_done;
         pal_q_ff   <= pal_mem[e_idx];
         pal_v_ff   <= pal_valid_ff[e_idx];
      end
   end

   logic [23:0] out_rgb;
   assign out_rgb    = use_pal_ff ? (pal_v_ff ? pal_q_ff : 24'd0) : rgb_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, out_rgb[7:0], out_rgb[15:8], out_rgb[23:16], y_ff, x_ff,
                        kind_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

endmodule

`default_nettype wire

[test/bmp_stream_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmp_stream_checker
// watches both channels of the bmp stream decoder, predicts every pixel and
// status result from the accepted file bytes and compares them in order
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_stream_checker
   import bmp_dec_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   input  wire                   req_tready,
   input  wire  [ReqDataW-1:0]   req_tdata,
   input  wire                   req_tuser,
   input  wire                   rsp_tvalid,
   input  wire                   rsp_tready,
   input  wire  [RspDataW-1:0]   rsp_tdata,
   input  wire                   rsp_tlast,
   input  wire                   rsp_tuser,
   output int                    errors,
   output int                    pending
);

   typedef enum logic [2:0] {
      ST_HEADER, ST_PREAMBLE, ST_PIXELS, ST_PAD, ST_IDLE
   } parse_state_type;

   typedef struct {
      kind_type    kind;
      logic [11:0] px;
      logic [11:0] py;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      bit          last;
      bit          done;
   } pixel_result_type;

   pixel_result_type expected_pixels[$];
   pixel_result_type produced[$];

   parse_state_type  phase;
   int unsigned      hdr_cnt, shift_word, pix_offset, img_w, img_h, depth, pal_cnt;
   int unsigned      row, col, row_phase, lane, colour_acc, fault;
   longint unsigned  byte_pos;
   logic [23:0]      pal_mem [256];

   function automatic logic [23:0] pal_lookup(int unsigned idx);
      if (idx >= PalDepth) return '0;
      return pal_mem[idx[7:0]];
   endfunction

   task automatic note_fault(int unsigned code);
      if (fault == 0 || code < fault) fault = code;
   endtask

   task automatic push_result(kind_type k, int unsigned x, int unsigned y,
                              logic [23:0] rgb, bit done);
      pixel_result_type r;
      r.kind = k;
      r.px = x[11:0];
      r.py = y[11:0];
      r.red = rgb[23:16];
      r.green = rgb[15:8];
      r.blue = rgb[7:0];
      r.last = 1'b0;
      r.done = done;
      produced.push_back(r);
   endtask

   task automatic emit_pixel(logic [23:0] rgb);
      push_result(KIND_PIXEL, col, img_h - 1 - row, rgb,
                  (row + 1 == img_h) && (col + 1 == img_w));
      col++;
   endtask

   task automatic end_row();
      row++;
      col = 0;
      row_phase = 0;
      lane = 0;
      phase = (row >= img_h) ? ST_IDLE : ST_PIXELS;
   endtask

   task automatic header_byte(int unsigned b);
      int unsigned hc;
      int unsigned d;
      hc = hdr_cnt;
      shift_word = (shift_word >> 8) | (b << 24);
      if (hc == HcMagic && (shift_word >> 16) != BmMagic) note_fault(KIND_BAD_MAGIC);
      if (hc == HcOffset) pix_offset = shift_word;
      if (hc == HcInfo && shift_word != InfoSize) note_fault(KIND_BAD_SIZE);
      if (hc == HcWidth) begin
         img_w = shift_word;
         if (img_w > MaxWidth) note_fault(KIND_TOO_LARGE);
      end
      if (hc == HcHeight) begin
         img_h = shift_word;
         if (img_h > MaxHeight) note_fault(KIND_TOO_LARGE);
      end
      if (hc == HcDepth) begin
         d = shift_word >> 16;
         depth = d & 31;
         if (d != 1 && d != 4 && d != 8 && d != 24) note_fault(KIND_BAD_DEPTH);
      end
      if (hc == HcCompress && shift_word != 0) note_fault(KIND_COMPRESS);
      hdr_cnt = hc + 1;
      if (hc != HcEnd) return;
      if (fault != 0) begin
         push_result(kind_type'(fault[2:0]), 0, 0, '0, 1'b0);
         phase = ST_IDLE;
         return;
      end
      pal_cnt = pix_offset >= HeaderBytes ? (pix_offset - HeaderBytes) / 4 : 0;
      if (pal_cnt > PalDepth) pal_cnt = PalDepth;
      byte_pos = HeaderBytes;
      row = 0;
      col = 0;
      row_phase = 0;
      lane = 0;
      if (img_w == 0 || img_h == 0) phase = ST_IDLE;
      else if (pal_cnt > 0 || pix_offset > HeaderBytes) phase = ST_PREAMBLE;
      else phase = ST_PIXELS;
   endtask

   task automatic preamble_byte(int unsigned b);
      longint unsigned rel;
      rel = byte_pos - HeaderBytes;
      if (rel < longint'(pal_cnt) * 4) begin
         case (rel[1:0])
            2'd0: colour_acc = b;
            2'd1: colour_acc = (colour_acc & 'hFF) | (b << 8);
            2'd2: pal_mem[rel[9:2]] = {b[7:0], colour_acc[15:0]};
            default: ;
         endcase
      end
      byte_pos++;
      if (byte_pos >= HeaderBytes + longint'(pal_cnt) * 4 && byte_pos >= pix_offset)
         phase = ST_PIXELS;
   endtask

   task automatic pixel_byte(int unsigned b);
      if (depth == 24) begin
         if (lane == 0) begin
            colour_acc = b;
            lane = 1;
         end else if (lane == 1) begin
            colour_acc = (colour_acc & 'hFF) | (b << 8);
            lane = 2;
         end else begin
            emit_pixel({b[7:0], colour_acc[15:0]});
            lane = 0;
         end
      end else if (depth == 8) begin
         emit_pixel(pal_lookup(b));
      end else if (depth == 4) begin
         if (col < img_w) emit_pixel(pal_lookup((b >> 4) & 15));
         if (col < img_w) emit_pixel(pal_lookup(b & 15));
      end else begin
         for (int j = 7; j >= 0; j--)
            if (col < img_w) emit_pixel(pal_lookup((b >> j) & 1));
      end
      row_phase = (row_phase + 1) & 3;
      if (col >= img_w) begin
         if (row_phase == 0) end_row();
         else phase = ST_PAD;
      end
   endtask

   task automatic decode_byte(int unsigned b, bit start);
      produced.delete();
      if (start) begin
         phase = ST_HEADER;
         hdr_cnt = 0;
         fault = 0;
      end
      case (phase)
         ST_HEADER:   header_byte(b);
         ST_PREAMBLE: preamble_byte(b);
         ST_PIXELS:   pixel_byte(b);
         ST_PAD: begin
            row_phase = (row_phase + 1) & 3;
            if (row_phase == 0) end_row();
         end
         default: ;
      endcase
      if (produced.size() > 0) produced[produced.size()-1].last = 1'b1;
      foreach (produced[i]) expected_pixels.push_back(produced[i]);
   endtask

   always @(posedge clock) begin
      pixel_result_type e;
      pixel_result_type a;
      if (reset) begin
         foreach (pal_mem[i]) pal_mem[i] = '0;
         phase = ST_HEADER;
         hdr_cnt = 0; shift_word = 0; pix_offset = 0; img_w = 0; img_h = 0;
         depth = 0; pal_cnt = 0; row = 0; col = 0; row_phase = 0; lane = 0;
         colour_acc = 0; fault = 0; byte_pos = 0;
         errors = 0;
         expected_pixels.delete();
      end else begin
         if (req_tvalid && req_tready) decode_byte(32'(req_tdata), req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            a.kind = kind_type'(rsp_tdata[2:0]);
            a.px = rsp_tdata[14:3];
            a.py = rsp_tdata[26:15];
            a.red = rsp_tdata[34:27];
            a.green = rsp_tdata[42:35];
            a.blue = rsp_tdata[50:43];
            a.last = rsp_tlast;
            a.done = rsp_tuser;
            if (expected_pixels.size() == 0) begin
               errors++;
               $display("%0t unexpected result kind=%0d x=%0d y=%0d rgb=%02h%02h%02h",
                        $time, a.kind, a.px, a.py, a.red, a.green, a.blue);
            end else begin
               e = expected_pixels.pop_front();
               if (e.kind != a.kind || e.px != a.px || e.py != a.py || e.red != a.red
                   || e.green != a.green || e.blue != a.blue || e.last != a.last
                   || e.done != a.done || rsp_tdata[55:51] != '0) begin
                  errors++;
                  $display("%0t mismatch exp kind=%0d x=%0d y=%0d rgb=%02h%02h%02h l=%0b d=%0b",
                           $time, e.kind, e.px, e.py, e.red, e.green, e.blue, e.last, e.done);
                  $display("%0t          act kind=%0d x=%0d y=%0d rgb=%02h%02h%02h l=%0b d=%0b",
                           $time, a.kind, a.px, a.py, a.red, a.green, a.blue, a.last, a.done);
               end
            end
         end
      end
      pending = expected_pixels.size();
   end

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// top of the bmp stream decoder bench: builds bmp files (good, faulty, cut
// short) byte by byte, streams them with random gaps and stalls and lets
// the checker judge every result
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import bmp_dec_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                req_tuser = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tlast;
   logic                rsp_tuser;
   int                  errors;
   int                  pending;

   bit                  idle_on = 1'b1;
   int                  hold_left = 0;
   int                  sent = 0;
   logic [7:0]          file_bytes[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bmp_stream_decoder dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   bmp_stream_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .errors(errors), .pending(pending)
   );

   // receiver side: random stalls plus a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= !(idle_on && $urandom_range(99) < 7);
         end
      end
   end

   initial begin
      #2ms;
      $display("bmp_stream_decoder verification failed");
      $finish;
   end

   task automatic push_le(int unsigned v, int n);
      for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
   endtask

   // one bmp file into file_bytes; cut > 0 keeps only that many bytes
   task automatic make_file(int unsigned magic, int unsigned info, int unsigned w,
                            int unsigned h, int unsigned bpp, int unsigned comp,
                            int unsigned offset, int unsigned cut, int unsigned tail);
      int unsigned row_bytes;
      bit          good;
      file_bytes.delete();
      push_le(magic, 2);
      push_le($urandom, 4);
      push_le(0, 4);
      push_le(offset, 4);
      push_le(info, 4);
      push_le(w, 4);
      push_le(h, 4);
      push_le(1, 2);
      push_le(bpp, 2);
      push_le(comp, 4);
      push_le($urandom, 4);
      repeat (16) file_bytes.push_back(8'($urandom));
      good = magic == BmMagic && info == InfoSize && comp == 0 && w <= MaxWidth
             && h <= MaxHeight && (bpp == 1 || bpp == 4 || bpp == 8 || bpp == 24);
      if (good) begin
         if (offset > HeaderBytes)
            repeat (offset - HeaderBytes) file_bytes.push_back(8'($urandom));
         row_bytes = ((w * bpp + 31) / 32) * 4;
         repeat (row_bytes * h) file_bytes.push_back(8'($urandom));
      end else begin
         repeat (8) file_bytes.push_back(8'($urandom));
      end
      repeat (tail) file_bytes.push_back(8'($urandom));
      if (cut > 0 && cut < file_bytes.size())
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) begin
         while (idle_on && $urandom_range(99) < 7) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= file_bytes[i];
         req_tuser <= (i == 0);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         sent++;
         @(negedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic random_file();
      int unsigned bpp;
      int unsigned pal;
      int unsigned pick;
      case ($urandom_range(3))
         0: bpp = 1;
         1: bpp = 4;
         2: bpp = 8;
         default: bpp = 24;
      endcase
      pal = $urandom_range(3) == 0 ? 0 : $urandom_range(20);
      pick = $urandom_range(19);
      case (pick)
         0: make_file(BmMagic ^ (1 << $urandom_range(15)), InfoSize, 3, 2, bpp, 0,
                      HeaderBytes, 0, 0);
         1: make_file(BmMagic, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(200), 0, 0);
         2: make_file(BmMagic, InfoSize, $urandom_range(12, 1), 3, bpp, 0,
                      HeaderBytes + 4 * pal, $urandom_range(80, 1), 0);
         default: make_file(BmMagic, InfoSize, $urandom_range(12, 1), $urandom_range(4, 1),
                            bpp, 0, HeaderBytes + 4 * pal + $urandom_range(3),
                            0, $urandom_range(3));
      endcase
      send_file();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // several header faults at once, the smallest code wins
      make_file(16'h0000, 0, 32'hFFFF_FFFF, 0, 3, 7, 0, 0, 0);           send_file();
      drain();
      // long receiver hold-off while the sender streams without gaps
      idle_on = 1'b0;
      hold_left = 300;
      make_file(BmMagic, InfoSize, 11, 1, 1, 0, HeaderBytes + 8, 0, 2);  send_file();
      idle_on = 1'b1;
      drain();

      // random files with some noise in between
      while (sent < 150) begin
         random_file();
         if ($urandom_range(4) == 0) begin
            file_bytes.delete();
            repeat ($urandom_range(6, 1)) file_bytes.push_back(8'($urandom));
            send_file();
         end
         if ($urandom_range(3) == 0) drain();
      end

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("bmp_stream_decoder verification clean");
      end else begin
         $display("bmp_stream_decoder verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
design/bmp_dec_pkg.sv
design/bmp_stream_decoder.sv
test/bmp_stream_checker.sv
test/tb.sv
